>>> rtl/core/tolerance_gated_window_mean_defines.svh
// Assertion macros of the window-mean RTL.
`ifndef TOLERANCE_GATED_WINDOW_MEAN_DEFINES_SVH
`define TOLERANCE_GATED_WINDOW_MEAN_DEFINES_SVH

// Checked property, masked while reset is held.
`define TGWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property, also during reset.
`define TGWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/tgwm_pkg.sv
// Types and constants of the tolerance-gated window mean.
`default_nettype none
package tgwm_pkg;

    localparam int PIX_W      = 8;
    localparam int QUO_W      = 8;
    localparam int GEO_W      = 12;
    localparam int TOL_W      = 8;
    localparam int RAD_W      = 3;
    localparam int SPAN_W     = 4;
    localparam int OFF_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int MAX_HEIGHT = 2048;
    // store geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_RADIUS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd3;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [GEO_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [GEO_W-1:0] RST_HEIGHT = 12'd480;
    localparam logic [TOL_W-1:0] RST_TOL    = 8'd8;
    localparam logic [RAD_W-1:0] RST_RADIUS = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_CENTRE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVGO,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/tolerance_gated_window_mean.sv
// Top level of the tolerance-gated window mean (sigma filter, box window).
//
// Usage: pixels of one plane enter in raster order on the s_ channel; tdata is
// the pixel, tuser[0] selects push (0) or drain (1). Each accepted beat gives
// zero or one smoothed pixel on the m_ channel, in raster order: tdata is the
// mean, tlast marks the last pixel of a row, tuser[0] the last of the plane.
// Geometry, tolerance and radius are written on the cfg_ port while idle; a
// geometry or radius write restarts the frame and drops pending outputs.
// One beat is in work at a time. For a beat that yields a pixel, the clipped
// window ((2r+1)^2 pixels at most) is read from the line store one pixel per
// cycle, then the mean goes through an 8-cell division chain, one quotient
// bit per cell. s_tready returns the cycle after the result beat is taken;
// while the receiver stalls, the result is held and no input is taken. Reset
// (aresetn, synchronous) clears positions, pending count and write pointer
// and loads the default registers; the line store is not cleared and needs
// no clearing pass.
`default_nettype none
module tolerance_gated_window_mean (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [tgwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tgwm_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  wire logic [0:0]                      s_tuser,   // [0] opcode
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [7:0]                      m_tdata,   // [7:0] pixel_out
    output logic                                 m_tlast,   // end_of_row
    output logic      [0:0]                      m_tuser    // [0] end_of_frame
);
    import tgwm_pkg::*;
    `include "tolerance_gated_window_mean_defines.svh"

    localparam int DEPTH   = MAX_WIDTH * (2 * MAX_RADIUS + 1) + 2 * MAX_RADIUS + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PEND_W  = ADDR_W + 1;
    localparam int SW      = ((ADDR_W > OFF_W) ? ADDR_W : OFF_W) + 1;
    localparam int CNT_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 2);
    localparam int SUM_W   = CNT_W + PIX_W;

    state_t state_reg, state_next;

    logic [GEO_W-1:0]  width_reg, height_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [RAD_W-1:0]  radius_reg;

    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [PEND_W-1:0] pending_reg;
    logic [GEO_W-1:0]  out_col_reg, out_row_reg;

    logic [ADDR_W-1:0] cen_addr_reg, cur_addr_reg, row_addr_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [SPAN_W-1:0] nrows_reg, ncols_reg, xi_reg, yi_reg;
    logic [PIX_W-1:0]  centre_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              hit_vld_reg;
    logic              eor_reg, eof_reg, eor_out_reg, eof_out_reg;
    logic [PIX_W-1:0]  pix_out_reg;

    logic              accept, push, mem_re, div_start;
    logic [ADDR_W-1:0] mem_raddr;
    logic [PIX_W-1:0]  mem_rdata;

    // ------------------------------------------------------------------
    // window geometry around the current output position
    logic [RAD_W-1:0]  dyu, ddn, dxl, dxr;
    logic [GEO_W-1:0]  hrem, wrem;
    logic [OFF_W-1:0]  look, off_up;
    logic              out_ready;
    logic [SW-1:0]     cen_diff, setup_diff, row_sum;
    logic [ADDR_W-1:0] cen_addr, setup_addr, row_next, cur_next;
    logic [PIX_W-1:0]  absdiff;
    logic              last_col, last_row_scan;

    always_comb begin
        hrem = height_reg - GEO_W'(1) - out_row_reg;
        wrem = width_reg - GEO_W'(1) - out_col_reg;
        dyu  = (out_row_reg > GEO_W'(radius_reg)) ? radius_reg : out_row_reg[RAD_W-1:0];
        dxl  = (out_col_reg > GEO_W'(radius_reg)) ? radius_reg : out_col_reg[RAD_W-1:0];
        ddn  = (hrem > GEO_W'(radius_reg)) ? radius_reg : hrem[RAD_W-1:0];
        dxr  = (wrem > GEO_W'(radius_reg)) ? radius_reg : wrem[RAD_W-1:0];
        look   = OFF_W'(ddn) * OFF_W'(width_reg) + OFF_W'(dxr);
        off_up = OFF_W'(dyu) * OFF_W'(width_reg) + OFF_W'(dxl);
        out_ready = (SW'(pending_reg) > SW'(look));
    end

    // modular address arithmetic on the circular store
    always_comb begin
        cen_diff = SW'(wr_ptr_reg) - SW'(pending_reg);
        if (SW'(wr_ptr_reg) >= SW'(pending_reg)) begin
            cen_addr = cen_diff[ADDR_W-1:0];
        end else begin
            cen_addr = ADDR_W'(cen_diff + SW'(DEPTH));
        end
        setup_diff = SW'(cen_addr_reg) - SW'(off_reg);
        if (SW'(cen_addr_reg) >= SW'(off_reg)) begin
            setup_addr = setup_diff[ADDR_W-1:0];
        end else begin
            setup_addr = ADDR_W'(setup_diff + SW'(DEPTH));
        end
        row_sum = SW'(row_addr_reg) + SW'(width_reg);
        if (row_sum >= SW'(DEPTH)) begin
            row_next = ADDR_W'(row_sum - SW'(DEPTH));
        end else begin
            row_next = row_sum[ADDR_W-1:0];
        end
        cur_next = (cur_addr_reg == ADDR_W'(DEPTH - 1)) ? '0 : cur_addr_reg + ADDR_W'(1);
        last_col      = (xi_reg == ncols_reg);
        last_row_scan = (yi_reg == nrows_reg);
        absdiff = (mem_rdata > centre_reg) ? (mem_rdata - centre_reg)
                                           : (centre_reg - mem_rdata);
    end

    // ------------------------------------------------------------------
    // line store
    assign accept = s_tvalid && s_tready;
    assign push   = accept && (s_tuser[0] == OP_PUSH);

    tgwm_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (s_tdata[PIX_W-1:0]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // division chain, one quotient bit per cell
    logic             div_vld [0:QUO_W];
    logic [SUM_W-1:0] div_rem [0:QUO_W];
    logic [CNT_W-1:0] div_cnt [0:QUO_W];
    logic [QUO_W-1:0] div_quo [0:QUO_W];

    assign div_vld[0] = div_start;
    assign div_rem[0] = sum_reg;
    assign div_cnt[0] = cnt_reg;
    assign div_quo[0] = '0;

    for (genvar i = 0; i < QUO_W; i++) begin : g_div
        tgwm_div_cell #(
            .SUM_W (SUM_W),
            .CNT_W (CNT_W),
            .BIT   (QUO_W - 1 - i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .in_vld  (div_vld[i]),
            .in_rem  (div_rem[i]),
            .in_cnt  (div_cnt[i]),
            .in_quo  (div_quo[i]),
            .out_vld (div_vld[i+1]),
            .out_rem (div_rem[i+1]),
            .out_cnt (div_cnt[i+1]),
            .out_quo (div_quo[i+1])
        );
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_CHECK;
            ST_CHECK:  state_next = out_ready ? ST_SETUP : ST_IDLE;
            ST_SETUP:  state_next = ST_CENTRE;
            ST_CENTRE: state_next = ST_SCAN;
            ST_SCAN:   if (last_col && last_row_scan) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_DIVGO;
            ST_DIVGO:  state_next = ST_DIV;
            ST_DIV:    if (div_vld[QUO_W]) state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = cur_addr_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SETUP: begin
                mem_re    = 1'b1;
                mem_raddr = cen_addr_reg;
            end
            ST_SCAN:  mem_re = 1'b1;
            ST_DIVGO: div_start = 1'b1;
            ST_OUT:   m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // registers, positions and pending count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            tol_reg     <= RST_TOL;
            radius_reg  <= RST_RADIUS;
            wr_ptr_reg  <= '0;
            pending_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            hit_vld_reg <= 1'b0;
        end else begin
            hit_vld_reg <= (state_reg == ST_SCAN);
            if (push) begin
                wr_ptr_reg  <= (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + ADDR_W'(1);
                pending_reg <= pending_reg + PEND_W'(1);
            end
            // result leaves the chain: step the output position
            if (state_reg == ST_DIV && div_vld[QUO_W]) begin
                pending_reg <= pending_reg - PEND_W'(1);
                if (out_col_reg + GEO_W'(1) >= width_reg) begin
                    out_col_reg <= '0;
                    out_row_reg <= (out_row_reg + GEO_W'(1) >= height_reg) ? '0
                                   : out_row_reg + GEO_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + GEO_W'(1);
                end
            end
            // config writes; geometry and radius restart the frame
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WIDTH: begin
                        if (cfg_data == '0) begin
                            width_reg <= GEO_W'(1);
                        end else if (int'(cfg_data) > MAX_WIDTH) begin
                            width_reg <= GEO_W'(MAX_WIDTH);
                        end else begin
                            width_reg <= cfg_data;
                        end
                        pending_reg <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end
                    REG_HEIGHT: begin
                        if (cfg_data == '0) begin
                            height_reg <= GEO_W'(1);
                        end else if (int'(cfg_data) > MAX_HEIGHT) begin
                            height_reg <= GEO_W'(MAX_HEIGHT);
                        end else begin
                            height_reg <= cfg_data;
                        end
                        pending_reg <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end
                    REG_TOL: tol_reg <= cfg_data[TOL_W-1:0];
                    REG_RADIUS: begin
                        if (int'(cfg_data[RAD_W-1:0]) > MAX_RADIUS) begin
                            radius_reg <= RAD_W'(MAX_RADIUS);
                        end else begin
                            radius_reg <= cfg_data[RAD_W-1:0];
                        end
                        pending_reg <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end
                    default: tol_reg <= tol_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // window scan and accumulation datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_CHECK: begin
                cen_addr_reg <= cen_addr;
                off_reg      <= off_up;
                nrows_reg    <= SPAN_W'(dyu) + SPAN_W'(ddn);
                ncols_reg    <= SPAN_W'(dxl) + SPAN_W'(dxr);
                xi_reg       <= '0;
                yi_reg       <= '0;
                eor_reg      <= (out_col_reg == width_reg - GEO_W'(1));
                eof_reg      <= (out_col_reg == width_reg - GEO_W'(1)) &&
                                (out_row_reg == height_reg - GEO_W'(1));
            end
            ST_SETUP: begin
                cur_addr_reg <= setup_addr;
                row_addr_reg <= setup_addr;
            end
            ST_CENTRE: begin
                centre_reg <= mem_rdata;
                sum_reg    <= SUM_W'(mem_rdata);
                cnt_reg    <= CNT_W'(1);
            end
            ST_SCAN: begin
                if (last_col) begin
                    xi_reg       <= '0;
                    yi_reg       <= yi_reg + SPAN_W'(1);
                    row_addr_reg <= row_next;
                    cur_addr_reg <= row_next;
                end else begin
                    xi_reg       <= xi_reg + SPAN_W'(1);
                    cur_addr_reg <= cur_next;
                end
            end
            ST_DIV: begin
                if (div_vld[QUO_W]) begin
                    pix_out_reg <= div_quo[QUO_W];
                    eor_out_reg <= eor_reg;
                    eof_out_reg <= eof_reg;
                end
            end
            default: begin
                xi_reg <= xi_reg;
            end
        endcase
        // neighbor read issued in the cycle before lands here
        if (hit_vld_reg && (absdiff < tol_reg)) begin
            sum_reg <= sum_reg + SUM_W'(mem_rdata);
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign m_tdata = pix_out_reg;
    assign m_tlast = eor_out_reg;
    assign m_tuser = eof_out_reg;

    // ------------------------------------------------------------------
    `TGWM_ASSERT(a_pending_bound, (pending_reg < PEND_W'(DEPTH)), "pending count overran the store")
    `TGWM_ASSERT(a_one_in_flight, !(s_tready && m_tvalid), "input taken while a result waits")
    `TGWM_ASSERT(a_chain_single, $onehot0({div_vld[1], div_vld[2], div_vld[3], div_vld[4],
        div_vld[5], div_vld[6], div_vld[7], div_vld[8]}), "more than one item in the division chain")
    `TGWM_ASSERT(a_div_nonzero, ((state_reg == ST_DIVGO) |-> (cnt_reg != '0)), "division by a zero count")
    `TGWM_ASSERT(a_div_rem, (div_vld[QUO_W] |-> (div_rem[QUO_W] < SUM_W'(div_cnt[QUO_W]))),
        "division remainder not below count")
    `TGWM_ASSERT(a_accept_check, ((s_tvalid && s_tready) |=> (state_reg == ST_CHECK)),
        "accepted beat not checked next cycle")

endmodule
`default_nettype wire

>>> rtl/core/tgwm_line_store.sv
// Circular pixel line store: one write port, one registered read port.
`default_nettype none
module tgwm_line_store #(
    parameter int DEPTH  = 18441,
    parameter int ADDR_W = 15
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [ADDR_W-1:0]         waddr,
    input  wire logic [tgwm_pkg::PIX_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [ADDR_W-1:0]         raddr,
    output logic      [tgwm_pkg::PIX_W-1:0] rdata
);
    import tgwm_pkg::*;

    logic [PIX_W-1:0] mem [0:DEPTH-1];

    // write side
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/tgwm_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes on.
`default_nettype none
module tgwm_div_cell #(
    parameter int SUM_W = 15,
    parameter int CNT_W = 7,
    parameter int BIT   = 7
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_vld,
    input  wire logic [SUM_W-1:0]           in_rem,
    input  wire logic [CNT_W-1:0]           in_cnt,
    input  wire logic [tgwm_pkg::QUO_W-1:0] in_quo,
    output logic                            out_vld,
    output logic      [SUM_W-1:0]           out_rem,
    output logic      [CNT_W-1:0]           out_cnt,
    output logic      [tgwm_pkg::QUO_W-1:0] out_quo
);
    import tgwm_pkg::*;

    logic [SUM_W-1:0] shifted;
    logic             fits;

    // trial subtract of count scaled to this bit
    assign shifted = SUM_W'(in_cnt) << BIT;
    assign fits    = (in_rem >= shifted);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld <= 1'b0;
        end else begin
            out_vld <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        out_cnt <= in_cnt;
        out_rem <= fits ? (in_rem - shifted) : in_rem;
        out_quo <= in_quo | (fits ? (QUO_W'(1) << BIT) : '0);
    end

endmodule
`default_nettype wire
